// ----- src/acp_pkg.sv -----
// ----------------------------------------------------------------------------
// acp_pkg: shared types, constants and helpers
// Fixed-point constants and data groups for the arm collision-point block.
// ----------------------------------------------------------------------------
`default_nettype none

package acp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANG_W  = 38;   // Q30 angle before reduction
    localparam int ROT_W  = 34;   // CORDIC datapath
    localparam int TRIG_W = 22;   // Q20 sine and cosine
    localparam int A_W    = 24;   // Q20 radial and lateral terms
    localparam int Q_W    = 48;   // Q40 intermediates
    localparam int POS_W  = 16;
    localparam int HGT_W  = 15;
    localparam int NPTS   = 8;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 38'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [ANG_W-1:0] THREE_PI_Q30 = 38'sd10119778278;
    localparam logic signed [ANG_W-1:0] FOUR_PI_Q30 = 38'sd13493037704;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [HGT_W-1:0] HEIGHT_RESET = 15'sd819;

    // Link constants, Q20.
    localparam logic signed [Q_W-1:0] K_0425   = 48'sd445645;
    localparam logic signed [Q_W-1:0] K_02125  = 48'sd222822;
    localparam logic signed [Q_W-1:0] K_039225 = 48'sd411304;
    localparam logic signed [Q_W-1:0] K_013075 = 48'sd137101;
    localparam logic signed [Q_W-1:0] K_02615  = 48'sd274203;
    localparam logic signed [Q_W-1:0] K_009465 = 48'sd99248;
    localparam logic signed [Q_W-1:0] K_00823  = 48'sd86298;
    localparam logic signed [Q_W-1:0] K_005915 = 48'sd62023;
    localparam logic signed [Q_W-1:0] K_006    = 48'sd62915;
    localparam logic signed [Q_W-1:0] K_014    = 48'sd146801;
    localparam logic signed [Q_W-1:0] K_011    = 48'sd115343;
    localparam logic signed [Q_W-1:0] K_002    = 48'sd20972;
    localparam logic signed [Q_W-1:0] K_00894  = 48'sd93743;
    localparam logic signed [Q_W-1:0] K_00447  = 48'sd46871;
    localparam logic signed [Q_W-1:0] K_008945 = 48'sd93795;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s2;
        logic signed [TRIG_W-1:0] c2;
        logic signed [TRIG_W-1:0] s23;
        logic signed [TRIG_W-1:0] c23;
        logic signed [TRIG_W-1:0] s234;
        logic signed [TRIG_W-1:0] c234;
        logic signed [TRIG_W-1:0] s5;
        logic signed [TRIG_W-1:0] c5;
    } t_trig;

    typedef struct packed {
        logic [NPTS-1:0][A_W-1:0]   a;
        logic [NPTS-1:0][A_W-1:0]   l;
        logic [NPTS-1:0][POS_W-1:0] z;
        logic signed [TRIG_W-1:0]   c1;
        logic signed [TRIG_W-1:0]   s1;
    } t_point_set;

    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] v;
        case (i)
            0:  v = 31'd843314857;
            1:  v = 31'd497837829;
            2:  v = 31'd263043837;
            3:  v = 31'd133525159;
            4:  v = 31'd67021687;
            5:  v = 31'd33543516;
            6:  v = 31'd16775851;
            7:  v = 31'd8388437;
            8:  v = 31'd4194283;
            9:  v = 31'd2097149;
            10: v = 31'd1048576;
            11: v = 31'd524288;
            12: v = 31'd262144;
            13: v = 31'd131072;
            14: v = 31'd65536;
            15: v = 31'd32768;
            16: v = 31'd16384;
            17: v = 31'd8192;
            18: v = 31'd4096;
            19: v = 31'd2048;
            20: v = 31'd1024;
            21: v = 31'd512;
            22: v = 31'd256;
            23: v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // Round half up by a fixed shift.
    function automatic logic signed [Q_W-1:0] rnd_q(input logic signed [Q_W-1:0] v,
                                                   input int s);
        logic signed [Q_W-1:0] b;
        b = 48'sd1 <<< (s - 1);
        return (v + b) >>> s;
    endfunction

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [Q_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] mulk(input logic signed [Q_W-1:0] k,
                                                  input logic signed [TRIG_W-1:0] t);
        return k * Q_W'(t);
    endfunction

endpackage

`default_nettype wire

// ----- src/arm_collision_point_kinematics.sv -----
// Output: the eight points of an item leave one point per cycle while the
// result side is ready, sent one after another by the point serializer.
// The front pipeline keeps taking new items while the serializer is busy,
// until its last stage holds an item that waits for the serializer.
// Reset: synchronous, active low; clears all valid flags and loads the
// height offset with 819.
// ----------------------------------------------------------------------------
// arm_collision_point_kinematics: collision points of a six-axis arm
// Five CORDIC lanes in parallel, a merge pipeline and a point serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_collision_point_kinematics #(
    parameter int CORDIC_STEPS = acp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [15:0]                i_angle_base,
    input  wire logic signed [15:0]                i_angle_shoulder,
    input  wire logic signed [15:0]                i_angle_elbow,
    input  wire logic signed [15:0]                i_angle_wrist_one,
    input  wire logic signed [15:0]                i_angle_wrist_two,
    input  wire logic signed [15:0]                i_angle_wrist_three,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic signed [acp_pkg::HGT_W-1:0]  i_cfg_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [2:0]                             o_point_index,
    output logic signed [acp_pkg::POS_W-1:0]       o_pos_x,
    output logic signed [acp_pkg::POS_W-1:0]       o_pos_y,
    output logic signed [acp_pkg::POS_W-1:0]       o_pos_z,
    output logic                                   o_last_point
);
    import acp_pkg::*;

    localparam int FL = CORDIC_STEPS + 9;

    logic signed [HGT_W-1:0] r_height;
    logic [FL-1:0]           r_fv;
    logic                    w_fadv, w_take;
    logic signed [ANG_W-1:0] w_t1, w_t2, w_t3, w_t4, w_t5;
    logic signed [ANG_W-1:0] r_t1, r_t2, r_t23, r_t234, r_t5;
    logic                    w_unused;
    t_trig                   w_trig;
    t_point_set              w_set;

    // Q3.12 to Q30
    assign w_t1 = {{4{i_angle_base[15]}}, i_angle_base, 18'd0};
    assign w_t2 = {{4{i_angle_shoulder[15]}}, i_angle_shoulder, 18'd0};
    assign w_t3 = {{4{i_angle_elbow[15]}}, i_angle_elbow, 18'd0};
    assign w_t4 = {{4{i_angle_wrist_one[15]}}, i_angle_wrist_one, 18'd0};
    assign w_t5 = {{4{i_angle_wrist_two[15]}}, i_angle_wrist_two, 18'd0};
    // The last wrist joint moves no collision point.
    assign w_unused = ^i_angle_wrist_three;

    assign w_fadv      = !r_fv[FL-1] || w_take;
    assign o_ready     = w_fadv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv     <= '0;
            r_height <= HEIGHT_RESET;
        end else begin
            if (w_fadv) begin
                r_fv <= {r_fv[FL-2:0], i_valid & ~w_unused | i_valid & w_unused};
            end
            if (i_cfg_valid) begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fadv) begin
            r_t1   <= w_t1;
            r_t2   <= w_t2;
            r_t23  <= w_t2 + w_t3;
            r_t234 <= w_t2 + w_t3 + w_t4;
            r_t5   <= w_t5;
        end
    end

    acp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane1 (
        .i_clk(i_clk), .i_en(w_fadv), .i_angle(r_t1),
        .o_sin(w_trig.s1), .o_cos(w_trig.c1)
    );
    acp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane2 (
        .i_clk(i_clk), .i_en(w_fadv), .i_angle(r_t2),
        .o_sin(w_trig.s2), .o_cos(w_trig.c2)
    );
    acp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane23 (
        .i_clk(i_clk), .i_en(w_fadv), .i_angle(r_t23),
        .o_sin(w_trig.s23), .o_cos(w_trig.c23)
    );
    acp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane234 (
        .i_clk(i_clk), .i_en(w_fadv), .i_angle(r_t234),
        .o_sin(w_trig.s234), .o_cos(w_trig.c234)
    );
    acp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane5 (
        .i_clk(i_clk), .i_en(w_fadv), .i_angle(r_t5),
        .o_sin(w_trig.s5), .o_cos(w_trig.c5)
    );

    acp_merge u_merge (
        .i_clk(i_clk), .i_en(w_fadv), .i_trig(w_trig),
        .i_height(r_height), .o_set(w_set)
    );

    acp_point_emit u_emit (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_set_valid(r_fv[FL-1]),
        .i_set(w_set),
        .o_take(w_take),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_point_index(o_point_index),
        .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z),
        .o_last_point(o_last_point)
    );

endmodule

`default_nettype wire

// ----- src/acp_cordic_lane.sv -----
// ----------------------------------------------------------------------------
// acp_cordic_lane: pipelined sine and cosine of one angle
// Range reduction into (-pi, pi], quadrant fold, then one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_cordic_lane #(
    parameter int STEPS = acp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [acp_pkg::ANG_W-1:0]  i_angle,
    output logic signed [acp_pkg::TRIG_W-1:0]      o_sin,
    output logic signed [acp_pkg::TRIG_W-1:0]      o_cos
);
    import acp_pkg::*;

    logic signed [ANG_W-1:0] r_r1, r_r2, r_r3;
    logic signed [ANG_W-1:0] n_r1, n_r2, n_r3, w_fold;
    logic                    w_neg;
    logic signed [ROT_W-1:0] r_x [STEPS+1];
    logic signed [ROT_W-1:0] r_y [STEPS+1];
    logic signed [ROT_W-1:0] r_z [STEPS+1];
    logic                    r_ng [STEPS+1];
    logic signed [ROT_W-1:0] w_xf, w_yf, w_cs, w_sn;
    localparam logic signed [ROT_W-1:0] RND10 = 34'sd512;

    always_comb begin
        if (i_angle > THREE_PI_Q30) begin
            n_r1 = i_angle - FOUR_PI_Q30;
        end else if (i_angle <= -THREE_PI_Q30) begin
            n_r1 = i_angle + FOUR_PI_Q30;
        end else begin
            n_r1 = i_angle;
        end
        if (r_r1 > THREE_PI_Q30) begin
            n_r2 = r_r1 - FOUR_PI_Q30;
        end else if (r_r1 <= -THREE_PI_Q30) begin
            n_r2 = r_r1 + FOUR_PI_Q30;
        end else begin
            n_r2 = r_r1;
        end
        if (r_r2 > PI_Q30) begin
            n_r3 = r_r2 - TWO_PI_Q30;
        end else if (r_r2 <= -PI_Q30) begin
            n_r3 = r_r2 + TWO_PI_Q30;
        end else begin
            n_r3 = r_r2;
        end
        // Beyond a quarter turn, rotate by half a turn and flip both outputs.
        if (r_r3 > HALF_PI_Q30) begin
            w_fold = r_r3 - PI_Q30;
            w_neg  = 1'b1;
        end else if (r_r3 < -HALF_PI_Q30) begin
            w_fold = r_r3 + PI_Q30;
            w_neg  = 1'b1;
        end else begin
            w_fold = r_r3;
            w_neg  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1    <= n_r1;
            r_r2    <= n_r2;
            r_r3    <= n_r3;
            r_z[0]  <= w_fold[ROT_W-1:0];
            r_ng[0] <= w_neg;
            r_x[0]  <= CORDIC_GAIN;
            r_y[0]  <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ng[i+1] <= r_ng[i];
                if (!r_z[i][ROT_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({3'b000, atan_q30(i)});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({3'b000, atan_q30(i)});
                end
            end
        end
    end

    always_comb begin
        w_xf = r_ng[STEPS] ? -r_x[STEPS] : r_x[STEPS];
        w_yf = r_ng[STEPS] ? -r_y[STEPS] : r_y[STEPS];
        w_cs = (w_xf + RND10) >>> 10;
        w_sn = (w_yf + RND10) >>> 10;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= w_cs[TRIG_W-1:0];
            o_sin <= w_sn[TRIG_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- src/acp_merge.sv -----
// ----------------------------------------------------------------------------
// acp_merge: combines the lane results into the eight link terms
// Three stages: link products, triple products and sums, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire acp_pkg::t_trig                    i_trig,
    input  wire logic signed [acp_pkg::HGT_W-1:0]  i_height,
    output acp_pkg::t_point_set                    o_set
);
    import acp_pkg::*;

    // stage one
    logic signed [Q_W-1:0] r_pc2a, r_pc2b, r_pc23a, r_pc23b, r_pc23c;
    logic signed [Q_W-1:0] r_ps2a, r_ps2b, r_ps23a, r_ps23b, r_ps23c;
    logic signed [Q_W-1:0] r_ps234, r_pc234, r_qc234, r_qs234, r_qc5;
    logic signed [TRIG_W-1:0] r_s5, r_c1a, r_s1a;
    // stage two
    logic signed [Q_W-1:0] r_a [NPTS];
    logic signed [Q_W-1:0] r_z [NPTS];
    logic signed [Q_W-1:0] r_l7, r_ta, r_tz;
    logic signed [TRIG_W-1:0] r_c1b, r_s1b;
    logic signed [63:0] w_pa, w_pz, w_ta, w_tz;
    logic signed [Q_W-1:0] n_a [NPTS];
    logic signed [Q_W-1:0] n_z [NPTS];
    logic signed [Q_W-1:0] w_ar [NPTS];
    logic signed [Q_W-1:0] w_zr [NPTS];
    logic signed [Q_W-1:0] w_lk [NPTS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc2a  <= mulk(K_02125, i_trig.c2);
            r_pc2b  <= mulk(K_0425, i_trig.c2);
            r_pc23a <= mulk(K_013075, i_trig.c23);
            r_pc23b <= mulk(K_02615, i_trig.c23);
            r_pc23c <= mulk(K_039225, i_trig.c23);
            r_ps2a  <= mulk(K_02125, i_trig.s2);
            r_ps2b  <= mulk(K_0425, i_trig.s2);
            r_ps23a <= mulk(K_013075, i_trig.s23);
            r_ps23b <= mulk(K_02615, i_trig.s23);
            r_ps23c <= mulk(K_039225, i_trig.s23);
            r_ps234 <= mulk(K_009465, i_trig.s234);
            r_pc234 <= mulk(K_009465, i_trig.c234);
            r_qc234 <= mulk(K_00823, i_trig.c234);
            r_qs234 <= mulk(K_00823, i_trig.s234);
            r_qc5   <= mulk(K_00823, i_trig.c5);
            r_s5    <= i_trig.s5;
            r_c1a   <= i_trig.c1;
            r_s1a   <= i_trig.s1;
        end
    end

    always_comb begin
        w_pa = 64'(r_qc234) * 64'(r_s5);
        w_pz = 64'(r_qs234) * 64'(r_s5);
        w_ta = (w_pa + 64'sd524288) >>> 20;
        w_tz = (w_pz + 64'sd524288) >>> 20;
        n_a[0] = '0;
        n_a[1] = '0;
        n_a[2] = -r_pc2a;
        n_a[3] = -r_pc2b;
        n_a[4] = -r_pc2b - r_pc23a;
        n_a[5] = -r_pc2b - r_pc23b;
        n_a[6] = -r_pc2b - r_pc23c;
        n_a[7] = -r_pc2b - r_pc23c + r_ps234;
        n_z[0] = '0;
        n_z[1] = K_00894 <<< 20;
        n_z[2] = (K_00447 <<< 20) - r_ps2a;
        n_z[3] = (K_00894 <<< 20) - r_ps2b;
        n_z[4] = (K_00894 <<< 20) - r_ps2b - r_ps23a;
        n_z[5] = (K_00894 <<< 20) - r_ps2b - r_ps23b;
        n_z[6] = (K_00894 <<< 20) - r_ps2b - r_ps23c;
        n_z[7] = (K_008945 <<< 20) - r_ps2b - r_ps23c - r_pc234;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_z   <= n_z;
            r_ta  <= w_ta[Q_W-1:0];
            r_tz  <= w_tz[Q_W-1:0];
            r_l7  <= rnd_q((K_005915 <<< 20) + r_qc5, 20);
            r_c1b <= r_c1a;
            r_s1b <= r_s1a;
        end
    end

    always_comb begin
        w_lk[0] = '0;
        w_lk[1] = K_006;
        w_lk[2] = K_014;
        w_lk[3] = K_011;
        w_lk[4] = K_002;
        w_lk[5] = K_002;
        w_lk[6] = K_006;
        w_lk[7] = r_l7;
    end

    // The tool point also takes the rounded triple products.
    always_comb begin
        for (int k = 0; k < NPTS; k++) begin
            if (k == NPTS - 1) begin
                w_ar[k] = rnd_q(r_a[k] - r_ta, 20);
                w_zr[k] = rnd_q(r_z[k] - r_tz, 27) + Q_W'(i_height);
            end else begin
                w_ar[k] = rnd_q(r_a[k], 20);
                w_zr[k] = rnd_q(r_z[k], 27) + Q_W'(i_height);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NPTS; k++) begin
                o_set.a[k] <= w_ar[k][A_W-1:0];
                o_set.l[k] <= w_lk[k][A_W-1:0];
                // The base point carries no mounting height.
                if (k == 0) begin
                    o_set.z[k] <= '0;
                end else begin
                    o_set.z[k] <= sat16(w_zr[k]);
                end
            end
            o_set.c1 <= r_c1b;
            o_set.s1 <= r_s1b;
        end
    end

endmodule

`default_nettype wire

// ----- src/acp_point_emit.sv -----
// ----------------------------------------------------------------------------
// acp_point_emit: serializes one item's eight points
// Holds a point set, rotates one point per unstalled cycle about base axis.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_point_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_set_valid,
    input  wire acp_pkg::t_point_set           i_set,
    output logic                               o_take,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_point_index,
    output logic signed [acp_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [acp_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [acp_pkg::POS_W-1:0]   o_pos_z,
    output logic                               o_last_point
);
    import acp_pkg::*;

    localparam logic [2:0] LAST_K = 3'(NPTS - 1);

    t_point_set              r_set;
    logic                    r_sv, r_pv;
    logic [2:0]              r_k, r_pk;
    logic signed [Q_W-1:0]   r_ca, r_sl, r_sa, r_cl;
    logic signed [POS_W-1:0] r_pz;
    logic                    w_padv, w_emit, w_emit_last;
    logic signed [Q_W-1:0]   w_a, w_l;

    assign w_padv      = !o_valid || i_ready;
    assign w_emit      = r_sv && w_padv;
    assign w_emit_last = w_emit && (r_k == LAST_K);
    assign o_take      = i_set_valid && (!r_sv || w_emit_last);
    assign w_a         = Q_W'($signed(r_set.a[r_k]));
    assign w_l         = Q_W'($signed(r_set.l[r_k]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= 1'b0;
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (o_take) begin
                r_sv <= 1'b1;
                r_k  <= '0;
            end else if (w_emit_last) begin
                r_sv <= 1'b0;
            end else if (w_emit) begin
                r_k <= r_k + 3'd1;
            end
            if (w_padv) begin
                r_pv    <= w_emit;
                o_valid <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_set <= i_set;
        end
        if (w_padv) begin
            r_pk <= r_k;
            r_pz <= $signed(r_set.z[r_k]);
            r_ca <= Q_W'(r_set.c1) * w_a;
            r_sl <= Q_W'(r_set.s1) * w_l;
            r_sa <= Q_W'(r_set.s1) * w_a;
            r_cl <= Q_W'(r_set.c1) * w_l;
            o_point_index <= r_pk;
            o_last_point  <= (r_pk == LAST_K);
            o_pos_x <= sat16(rnd_q(r_ca + r_sl, 27));
            o_pos_y <= sat16(rnd_q(r_sa - r_cl, 27));
            o_pos_z <= r_pz;
        end
    end

endmodule

`default_nettype wire

// ----- src/acp_checker.sv -----
// ----------------------------------------------------------------------------
// acp_checker: port-level checks for the collision-point block
// Watches the result channel and the reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_point_index,
    input wire logic [15:0] o_pos_x,
    input wire logic [15:0] o_pos_y,
    input wire logic [15:0] o_pos_z,
    input wire logic        o_last_point
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_point == (o_point_index == 3'd7)))
        else $error("last flag does not match the tool point");

    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_index == 3'd0) |->
        (o_pos_x == 16'd0 && o_pos_y == 16'd0 && o_pos_z == 16'd0))
        else $error("base point is not at the origin");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_point) ##1 o_valid |->
        o_point_index == $past(o_point_index) + 3'd1)
        else $error("points out of order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x) && $stable(o_point_index)))
        else $error("stalled item changed");

endmodule

bind arm_collision_point_kinematics acp_checker u_acp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_point_index(o_point_index),
    .o_pos_x(o_pos_x),
    .o_pos_y(o_pos_y),
    .o_pos_z(o_pos_z),
    .o_last_point(o_last_point)
);

`default_nettype wire

// ----- bench/arm_collision_point_kinematics_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_collision_point_kinematics_checker: point predictor and comparator
// Watches the angle, height and point channels, computes the eight expected
// points of every accepted item and compares each accepted point in order.
// ----------------------------------------------------------------------------

module arm_collision_point_kinematics_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [15:0]  ang_base,
    input  logic signed [15:0]  ang_shoulder,
    input  logic signed [15:0]  ang_elbow,
    input  logic signed [15:0]  ang_wrist_one,
    input  logic signed [15:0]  ang_wrist_two,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic signed [14:0]  cfg_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [2:0]          point_index,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  pos_z,
    input  logic                last_point,
    output int                  fail_count,
    output int                  points_pending
);

    typedef struct {
        logic [2:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } t_point;

    localparam longint TWO_PI = 64'sd6746518852;
    localparam longint PI = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;

    t_point expected_points[$];
    logic signed [14:0] mount_height;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl [0:15] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
            524288, 262144, 131072, 65536, 32768};
        return tbl[i];
    endfunction

    task automatic rotate(input longint ang, output longint sn, output longint cs);
        longint r, x, y, dx, dy;
        bit flip;
        r = ang % TWO_PI;
        x = 652032874;
        y = 0;
        flip = 0;
        if (r < 0) r += TWO_PI;
        if (r > PI) r -= TWO_PI;
        if (r > HALF_PI) begin
            r -= PI;
            flip = 1;
        end else if (r < -HALF_PI) begin
            r += PI;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (r >= 0) begin
                x -= dx; y += dy; r -= arctan_step(i);
            end else begin
                x += dx; y -= dy; r += arctan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cs = round_shift(x, 10);
        sn = round_shift(y, 10);
    endtask

    task automatic predict_points();
        longint t1, t2, t3, t4, t5;
        longint s1, c1, s2, c2, s23, c23, s234, c234, s5, c5;
        longint rad[8], lat[8], hgt[8];
        longint a, l;
        t_point p;
        t1 = longint'(ang_base) * 262144;
        t2 = longint'(ang_shoulder) * 262144;
        t3 = longint'(ang_elbow) * 262144;
        t4 = longint'(ang_wrist_one) * 262144;
        t5 = longint'(ang_wrist_two) * 262144;
        rotate(t1, s1, c1);
        rotate(t2, s2, c2);
        rotate(t2 + t3, s23, c23);
        rotate(t2 + t3 + t4, s234, c234);
        rotate(t5, s5, c5);
        rad[1] = 0;
        rad[2] = -222822 * c2;
        rad[3] = -445645 * c2;
        rad[4] = rad[3] - 137101 * c23;
        rad[5] = rad[3] - 274203 * c23;
        rad[6] = rad[3] - 411304 * c23;
        rad[7] = rad[6] + 99248 * s234 - round_shift(86298 * c234 * s5, 20);
        lat[1] = 64'sd62915 <<< 20;
        lat[2] = 64'sd146801 <<< 20;
        lat[3] = 64'sd115343 <<< 20;
        lat[4] = 64'sd20972 <<< 20;
        lat[5] = 64'sd20972 <<< 20;
        lat[6] = 64'sd62915 <<< 20;
        lat[7] = (64'sd62023 <<< 20) + 86298 * c5;
        hgt[1] = 64'sd93743 <<< 20;
        hgt[2] = (64'sd46871 <<< 20) - 222822 * s2;
        hgt[3] = (64'sd93743 <<< 20) - 445645 * s2;
        hgt[4] = hgt[3] - 137101 * s23;
        hgt[5] = hgt[3] - 274203 * s23;
        hgt[6] = hgt[3] - 411304 * s23;
        hgt[7] = (64'sd93795 <<< 20) - 445645 * s2 - 411304 * s23 - 99248 * c234
                 - round_shift(86298 * s5 * s234, 20);
        for (int k = 0; k < 8; k++) begin
            p.idx = k[2:0];
            p.last = (k == 7);
            if (k == 0) begin
                p.x = 0; p.y = 0; p.z = 0;
            end else begin
                a = round_shift(rad[k], 20);
                l = round_shift(lat[k], 20);
                p.x = 16'(clamp16(round_shift(c1 * a + s1 * l, 27)));
                p.y = 16'(clamp16(round_shift(s1 * a - c1 * l, 27)));
                p.z = 16'(clamp16(round_shift(hgt[k], 27) + longint'(mount_height)));
            end
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    assign points_pending = expected_points.size();

    always @(posedge clk) begin
        t_point e;
        if (!rst_n) begin
            mount_height <= 15'sd819;
            expected_points.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) mount_height <= cfg_data;
            if (in_valid && in_ready) predict_points();
            if (out_valid && out_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point idx=%0d x=%0d y=%0d z=%0d", $time,
                             point_index, pos_x, pos_y, pos_z);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_points.pop_front();
                    if (e.idx !== point_index || e.x !== pos_x || e.y !== pos_y ||
                        e.z !== pos_z || e.last !== last_point) begin
                        $display("%0t: point mismatch expected idx=%0d x=%0d y=%0d z=%0d last=%0d",
                                 $time, e.idx, e.x, e.y, e.z, e.last);
                        $display("%0t:                  actual idx=%0d x=%0d y=%0d z=%0d last=%0d",
                                 $time, point_index, pos_x, pos_y, pos_z, last_point);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/arm_collision_point_kinematics_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_collision_point_kinematics_test: top of the kinematics bench
// Drives joint angles and height writes with random idling on both sides,
// and reports the verdict from the checker's failure count and a stall watchdog.
// ----------------------------------------------------------------------------

module arm_collision_point_kinematics_test;

    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic signed [15:0] ang [6];
    logic cfg_valid, cfg_ready;
    logic signed [14:0] cfg_data;
    logic out_valid, out_ready;
    logic [2:0] point_index;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic last_point;
    int fail_count, points_pending;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;

    arm_collision_point_kinematics dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_angle_base(ang[0]), .i_angle_shoulder(ang[1]), .i_angle_elbow(ang[2]),
        .i_angle_wrist_one(ang[3]), .i_angle_wrist_two(ang[4]),
        .i_angle_wrist_three(ang[5]),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_point_index(point_index), .o_pos_x(pos_x), .o_pos_y(pos_y),
        .o_pos_z(pos_z), .o_last_point(last_point)
    );

    arm_collision_point_kinematics_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ang_base(ang[0]), .ang_shoulder(ang[1]), .ang_elbow(ang[2]),
        .ang_wrist_one(ang[3]), .ang_wrist_two(ang[4]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_index(point_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .last_point(last_point),
        .fail_count(fail_count), .points_pending(points_pending)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // The receiver stalls at random, at the rate the current phase sets.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Any accepted item or point or write restarts the stall count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("arm_collision_point_kinematics verification failed");
            $finish;
        end
    end

    // Valid stays high from one item to the next unless the sender idles.
    task automatic send_angles(input logic signed [15:0] a0, a1, a2, a3, a4, a5);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_valid <= 1;
        ang[0] <= a0; ang[1] <= a1; ang[2] <= a2;
        ang[3] <= a3; ang[4] <= a4; ang[5] <= a5;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_angles();
        logic signed [15:0] r [6];
        for (int j = 0; j < 6; j++) begin
            case ($urandom_range(3))
                0: r[j] = 16'($urandom_range(16'h7fff, 0)) | 16'h8000;
                1: r[j] = 16'($urandom_range(6434)) - 16'sd3217;
                default: r[j] = 16'($urandom);
            endcase
        end
        send_angles(r[0], r[1], r[2], r[3], r[4], r[5]);
    endtask

    // Height writes only happen once every point has drained.
    task automatic write_height(input logic signed [14:0] h);
        in_valid <= 0;
        while (points_pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= h;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    initial begin
        logic signed [15:0] corner [4];
        corner = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd6434};
        rst_n = 0;
        in_valid = 0;
        cfg_valid = 0;
        cfg_data = 0;
        send_idle_pct = 18;
        recv_idle_pct = 72;
        for (int j = 0; j < 6; j++) ang[j] = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed corners at the reset height: zero pose, extremes, right angles.
        send_angles(0, 0, 0, 0, 0, 0);
        for (int j = 0; j < 4; j++) begin
            send_angles(corner[j], corner[j], corner[j], corner[j], corner[j], corner[j]);
        end
        send_angles(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_angles(6434, 6434, 6434, 6434, 6434, 0);
        send_angles(12868, -12868, 12868, -12868, 12868, 0);
        send_angles(-6434, -6434, 0, 0, -6434, 16'sh7fff);
        send_angles(0, 6434, 6434, 0, 0, 0);
        write_height(15'sh3fff);
        send_angles(0, 6434, 0, 0, 0, 0);
        send_angles(0, -6434, 0, 0, 0, 0);
        write_height(-15'sh4000);
        send_angles(0, 6434, 0, 0, 0, 0);
        send_angles(0, -6434, 0, 0, 0, 0);
        write_height(15'sd0);
        send_angles(3217, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 18 : 0;
            write_height(15'($urandom));
            for (int n = 0; n < 72; n++) begin
                if (n == 40) begin
                    in_valid <= 0;
                    while (points_pending != 0) @(negedge clk);
                end
                send_random_angles();
            end
        end
        write_height(15'sd819);
        send_random_angles();

        in_valid <= 0;
        while (points_pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("arm_collision_point_kinematics verification clean");
        end else begin
            $display("arm_collision_point_kinematics verification failed");
        end
        $finish;
    end

endmodule

// ----- arm_collision_point_kinematics.f -----
src/acp_pkg.sv
src/acp_cordic_lane.sv
src/acp_merge.sv
src/acp_point_emit.sv
src/arm_collision_point_kinematics.sv
src/acp_checker.sv
bench/arm_collision_point_kinematics_checker.sv
bench/arm_collision_point_kinematics_test.sv
